// ===== rtl/core/nearest_palette_colour_mapper_core_macros.svh =====
`ifndef NEAREST_PALETTE_COLOUR_MAPPER_CORE_MACROS_SVH
`define NEAREST_PALETTE_COLOUR_MAPPER_CORE_MACROS_SVH

// Property checked on every clock edge outside reset.
`define NPCM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define NPCM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define NPCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/npcm_pkg.sv =====
package npcm_pkg;

  localparam int unsigned PALETTE_ENTRIES = 64;
  localparam int unsigned ADDR_W     = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int unsigned INDEX_W    = 6;
  localparam int unsigned COLOUR_W   = 24;
  localparam int unsigned PIXEL_W    = 16;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned IDX_EXT_W  = (ADDR_W > INDEX_W) ? ADDR_W : INDEX_W;
  localparam int unsigned RANGE_W    = IDX_EXT_W + 1;
  localparam int unsigned SQ_W       = 2 * CHAN_W;
  localparam int unsigned SUM_W      = SQ_W + 2;
  localparam int unsigned ROOT_W     = SUM_W / 2;
  localparam int unsigned SQRT_STEPS = SUM_W / 2;
  localparam int unsigned RES_W      = SUM_W + 1;

  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_MAP   = 1'b1
  } action_e;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_PUSH  = 4'b1000
  } state_e;

  typedef struct packed {
    logic              wr_en;
    logic              pix_load;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_last;
    logic              out_load;
  } npcm_cmd_t;

  typedef struct packed {
    logic done;
  } npcm_status_t;

  typedef struct packed {
    logic [ADDR_W-1:0] idx;
    logic              last;
  } scan_tag_t;

endpackage

// ===== rtl/core/npcm_ram.sv =====
module npcm_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                            clk_i,
  input  logic                                            we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    waddr_i,
  input  logic [WIDTH-1:0]                                wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]    raddr_i,
  output logic [WIDTH-1:0]                                rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/npcm_isqrt.sv =====
module npcm_isqrt import npcm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  scan_tag_t         tag_i,
  input  logic [SUM_W-1:0]  value_i,
  output logic              valid_o,
  output scan_tag_t         tag_o,
  output logic [ROOT_W-1:0] root_o
);

  logic              vld_q [SQRT_STEPS];
  scan_tag_t         tag_q [SQRT_STEPS];
  logic [SUM_W-1:0]  rem_q [SQRT_STEPS];
  logic [RES_W-1:0]  res_q [SQRT_STEPS];
  logic [SUM_W-1:0]  rem_d [SQRT_STEPS];
  logic [RES_W-1:0]  res_d [SQRT_STEPS];

  // One digit of the root per stage.
  always_comb begin
    logic [SUM_W-1:0] rem_in;
    logic [RES_W-1:0] res_in;
    logic [RES_W-1:0] bit_v;
    logic [RES_W-1:0] trial;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      if (k == 0) begin
        rem_in = value_i;
        res_in = '0;
      end else begin
        rem_in = rem_q[k-1];
        res_in = res_q[k-1];
      end
      bit_v = RES_W'(1) << (2 * (SQRT_STEPS - 1 - k));
      trial = res_in + bit_v;
      if ({1'b0, rem_in} >= trial) begin
        rem_d[k] = rem_in - trial[SUM_W-1:0];
        res_d[k] = (res_in >> 1) + bit_v;
      end else begin
        rem_d[k] = rem_in;
        res_d[k] = res_in >> 1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < SQRT_STEPS; k++) begin
        vld_q[k] <= 1'b0;
      end
    end else begin
      for (int k = 0; k < SQRT_STEPS; k++) begin
        vld_q[k] <= (k == 0) ? valid_i : vld_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < SQRT_STEPS; k++) begin
      tag_q[k] <= (k == 0) ? tag_i : tag_q[k-1];
      rem_q[k] <= rem_d[k];
      res_q[k] <= res_d[k];
    end
  end

  assign valid_o = vld_q[SQRT_STEPS-1];
  assign tag_o   = tag_q[SQRT_STEPS-1];
  assign root_o  = res_q[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

// ===== rtl/core/npcm_datapath.sv =====
module npcm_datapath import npcm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  npcm_cmd_t           cmd_i,
  output npcm_status_t        status_o,
  input  logic [INDEX_W-1:0]  entry_index_i,
  input  logic [COLOUR_W-1:0] entry_colour_i,
  input  logic [PIXEL_W-1:0]  pixel_i,
  output logic [INDEX_W-1:0]  colour_index_o
);

  function automatic logic [CHAN_W-1:0] abs_diff(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  logic [IDX_EXT_W-1:0] wr_idx_ext;
  logic                 wr_en;
  logic [COLOUR_W-1:0]  rdata;

  logic [CHAN_W-1:0] px_r_q, px_g_q, px_b_q;

  logic              s1_vld_q;
  scan_tag_t         s1_tag_q;
  logic [CHAN_W-1:0] d_r, d_g, d_b;

  logic              s2_vld_q;
  scan_tag_t         s2_tag_q;
  logic [SQ_W-1:0]   sq_r_q, sq_g_q, sq_b_q;

  logic              s3_vld_q;
  scan_tag_t         s3_tag_q;
  logic [SUM_W-1:0]  sum_q;

  logic              rt_vld;
  scan_tag_t         rt_tag;
  logic [ROOT_W-1:0] rt_root;

  logic [ADDR_W-1:0] best_idx_q;
  logic [ROOT_W-1:0] best_dist_q;
  logic              better;
  logic [IDX_EXT_W-1:0] best_ext;
  logic [INDEX_W-1:0] out_idx_q;
  scan_tag_t         rd_tag;

  // Writes past the palette are dropped.
  assign wr_idx_ext = IDX_EXT_W'(entry_index_i);
  assign wr_en      = cmd_i.wr_en && ({1'b0, wr_idx_ext} < RANGE_W'(PALETTE_ENTRIES));

  npcm_ram #(
    .WIDTH(COLOUR_W),
    .DEPTH(PALETTE_ENTRIES)
  ) u_palette (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_idx_ext[ADDR_W-1:0]),
    .wdata_i(entry_colour_i),
    .raddr_i(cmd_i.rd_addr),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_load) begin
      px_r_q <= {pixel_i[15:11], 3'b000};
      px_g_q <= {pixel_i[10:5], 2'b00};
      px_b_q <= {pixel_i[4:0], 3'b000};
    end
  end

  assign rd_tag.idx  = cmd_i.rd_addr;
  assign rd_tag.last = cmd_i.rd_last;

  assign d_r = abs_diff(px_r_q, rdata[23:16]);
  assign d_g = abs_diff(px_g_q, rdata[15:8]);
  assign d_b = abs_diff(px_b_q, rdata[7:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= cmd_i.rd_en;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_tag_q <= rd_tag;
    s2_tag_q <= s1_tag_q;
    sq_r_q   <= SQ_W'(d_r) * SQ_W'(d_r);
    sq_g_q   <= SQ_W'(d_g) * SQ_W'(d_g);
    sq_b_q   <= SQ_W'(d_b) * SQ_W'(d_b);
    s3_tag_q <= s2_tag_q;
    sum_q    <= SUM_W'(sq_r_q) + SUM_W'(sq_g_q) + SUM_W'(sq_b_q);
  end

  npcm_isqrt u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s3_vld_q),
    .tag_i  (s3_tag_q),
    .value_i(sum_q),
    .valid_o(rt_vld),
    .tag_o  (rt_tag),
    .root_o (rt_root)
  );

  // Strictly smaller wins, so ties keep the lower index.
  assign better = (rt_tag.idx == '0) || (rt_root < best_dist_q);

  always_ff @(posedge clk_i) begin
    if (rt_vld && better) begin
      best_idx_q  <= rt_tag.idx;
      best_dist_q <= rt_root;
    end
  end

  assign best_ext = IDX_EXT_W'(best_idx_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_idx_q <= best_ext[INDEX_W-1:0];
    end
  end

  assign status_o.done  = rt_vld && rt_tag.last;
  assign colour_index_o = out_idx_q;

endmodule

// ===== rtl/core/npcm_ctrl.sv =====
`include "nearest_palette_colour_mapper_core_macros.svh"

module npcm_ctrl import npcm_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic         action_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output npcm_cmd_t    cmd_o,
  input  npcm_status_t status_i
);

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              cnt_last;

  assign cnt_last = (cnt_q == ADDR_W'(PALETTE_ENTRIES - 1));

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.rd_addr = cnt_q;
    cmd_o.rd_last = cnt_last;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (action_e'(action_i) == ACT_MAP) begin
            cmd_o.pix_load = 1'b1;
            cnt_d          = '0;
            state_d        = S_SCAN;
          end else begin
            cmd_o.wr_en = 1'b1;
          end
        end
      end
      S_SCAN: begin
        cmd_o.rd_en = 1'b1;
        if (cnt_last) begin
          state_d = S_DRAIN;
        end else begin
          cnt_d = cnt_q + ADDR_W'(1);
        end
      end
      S_DRAIN: begin
        if (status_i.done) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `NPCM_ASSERT_IMP(a_done_in_drain, status_i.done, state_q == S_DRAIN, "done outside drain")
  `NPCM_ASSERT_NEXT(a_scan_to_drain, cmd_o.rd_en && cmd_o.rd_last, state_q == S_DRAIN, "no drain")
  `NPCM_ASSERT_NEXT(a_load_sets_valid, cmd_o.out_load, out_valid_q, "result not presented")
  `NPCM_ASSERT(a_no_read_idle, !(cmd_o.rd_en && in_ready_o), "read while accepting")

endmodule

// ===== rtl/core/nearest_palette_colour_mapper_core.sv =====
// Channel | Signals                                                 | Direction
// in      | in_valid_i/in_ready_o, action_i, entry_index_i,         | sink
//         | entry_colour_i, pixel_i                                 |
// out     | out_valid_o/out_ready_i, colour_index_o                 | source
//
// A palette write is accepted in the idle state, which it does not leave. A pixel
// passes through the accept step, one palette RAM read per entry, a drain of the
// square/sum/square-root pipeline and a load of the output.
// Reset clears control only; palette contents are undefined until written.
// A stalled output holds the result; new items are taken meanwhile, and a
// following pixel waits only at its final output load.
module nearest_palette_colour_mapper_core import npcm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                action_i,
  input  logic [INDEX_W-1:0]  entry_index_i,
  input  logic [COLOUR_W-1:0] entry_colour_i,
  input  logic [PIXEL_W-1:0]  pixel_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [INDEX_W-1:0]  colour_index_o
);

  npcm_cmd_t    cmd;
  npcm_status_t status;

  npcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .action_i   (action_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  npcm_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .entry_index_i (entry_index_i),
    .entry_colour_i(entry_colour_i),
    .pixel_i       (pixel_i),
    .colour_index_o(colour_index_o)
  );

endmodule

// ===== bench/tb.sv =====
module tb import npcm_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_SLOTS        = 64;
  localparam int unsigned MAX_IDLE       = 17;
  localparam int unsigned HOLD_CYCLES    = 500;
  localparam int unsigned DRAIN_CYCLES   = 120;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS   = 1640;

  typedef struct {
    logic [PIXEL_W-1:0] pixel;
    logic [INDEX_W-1:0] index;
  } expected_map_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic                action_i;
  logic [INDEX_W-1:0]  entry_index_i;
  logic [COLOUR_W-1:0] entry_colour_i;
  logic [PIXEL_W-1:0]  pixel_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [INDEX_W-1:0]  colour_index_o;

  logic [COLOUR_W-1:0] palette_copy [N_SLOTS];
  expected_map_t       pending_index [$];
  int unsigned         mismatches;
  int unsigned         idle_cycles;
  int unsigned         hold_req;
  bit                  no_idle;

  nearest_palette_colour_mapper_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .action_i       (action_i),
    .entry_index_i  (entry_index_i),
    .entry_colour_i (entry_colour_i),
    .pixel_i        (pixel_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .colour_index_o (colour_index_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned floor_sqrt(int unsigned v);
    int unsigned root;
    int unsigned trial;
    root = 0;
    for (int b = 9; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  function automatic logic [INDEX_W-1:0] nearest_entry(logic [PIXEL_W-1:0] px);
    int r, g, b, dr, dg, db;
    int unsigned cur_dist, best_dist, best;
    logic [COLOUR_W-1:0] e;
    r = int'(px[15:11]) << 3;
    g = int'(px[10:5]) << 2;
    b = int'(px[4:0]) << 3;
    best = 0;
    best_dist = 0;
    for (int i = 0; i < N_SLOTS; i++) begin
      e = palette_copy[i];
      dr = r - int'(e[23:16]);
      dg = g - int'(e[15:8]);
      db = b - int'(e[7:0]);
      cur_dist = floor_sqrt(dr * dr + dg * dg + db * db);
      if (i == 0 || cur_dist < best_dist) begin
        best = i;
        best_dist = cur_dist;
      end
    end
    return best[INDEX_W-1:0];
  endfunction

  task automatic report_mismatch(string what);
    $display("%0t ns: mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic send_item(action_e act, logic [INDEX_W-1:0] idx,
                           logic [COLOUR_W-1:0] col, logic [PIXEL_W-1:0] px);
    int unsigned gap;
    expected_map_t exp_item;
    gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    action_i       <= act;
    entry_index_i  <= idx;
    entry_colour_i <= col;
    pixel_i        <= px;
    do @(posedge clk_i); while (!in_ready_o);
    if (act == ACT_WRITE) begin
      palette_copy[idx] = col;
    end else begin
      exp_item.pixel = px;
      exp_item.index = nearest_entry(px);
      pending_index.push_back(exp_item);
    end
  endtask

  task automatic write_entry(logic [INDEX_W-1:0] idx, logic [COLOUR_W-1:0] col);
    send_item(ACT_WRITE, idx, col, PIXEL_W'($urandom));
  endtask

  task automatic map_pixel(logic [PIXEL_W-1:0] px);
    send_item(ACT_MAP, INDEX_W'($urandom), COLOUR_W'($urandom), px);
  endtask

  task automatic test_palette_load();
    logic [7:0] rr, gg, bb;
    write_entry(INDEX_W'(0), 24'h000000);
    for (int i = 1; i < N_SLOTS - 1; i++) begin
      rr = 8'(i * 4 + 2);
      gg = 8'(255 - i * 4);
      bb = 8'(i * 29 + 100);
      write_entry(INDEX_W'(i), {rr, gg, bb});
    end
    write_entry(INDEX_W'(N_SLOTS - 1), 24'hFFFFFF);
  endtask

  task automatic test_channel_extremes();
    map_pixel(16'h0000);
    map_pixel(16'hFFFF);
    map_pixel(16'hF800);
    map_pixel(16'h07E0);
    map_pixel(16'h001F);
    map_pixel(16'h0821);
    map_pixel(16'h8410);
    send_item(ACT_MAP, '1, '1, 16'h7BEF);
  endtask

  task automatic test_lowest_index_ties();
    // floor ties: sqrt(2) and 1 both floor to 1, lower slot wins
    write_entry(INDEX_W'(0), 24'h010100);
    write_entry(INDEX_W'(1), 24'h000001);
    map_pixel(16'h0000);
    write_entry(INDEX_W'(20), 24'h808080);
    write_entry(INDEX_W'(41), 24'h808080);
    map_pixel(16'h8410);
    send_item(ACT_WRITE, INDEX_W'(7), 24'h123456, 16'hFFFF);
    map_pixel({5'h02, 6'h0D, 5'h0A});
    write_entry(INDEX_W'(7), 24'hFFFFFF);
    map_pixel({5'h02, 6'h0D, 5'h0A});
  endtask

  task automatic test_output_backpressure();
    no_idle = 1'b1;
    hold_req = HOLD_CYCLES;
    for (int k = 0; k < 12; k++) map_pixel(PIXEL_W'($urandom));
    no_idle = 1'b0;
  endtask

  task automatic test_random_stream(int unsigned count);
    logic [COLOUR_W-1:0] col;
    logic [INDEX_W-1:0]  idx;
    int unsigned         sel;
    for (int unsigned k = 0; k < count; k++) begin
      if (k % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        idx = INDEX_W'($urandom_range(0, N_SLOTS - 1));
        col = COLOUR_W'($urandom);
        if ($urandom_range(0, 3) == 0)
          col = palette_copy[$urandom_range(0, N_SLOTS - 1)] ^ (COLOUR_W'($urandom) & 24'h030303);
        write_entry(idx, col);
      end else if (sel < 30) begin
        col = palette_copy[$urandom_range(0, N_SLOTS - 1)];
        map_pixel({col[23:19], col[15:10], col[7:3]});
      end else begin
        map_pixel(PIXEL_W'($urandom));
      end
    end
    no_idle = 1'b0;
  endtask

  // result sink: per-transfer random stall, plus an optional long hold
  initial begin
    int unsigned stall;
    out_ready_i = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (hold_req != 0) begin
        stall = hold_req;
        hold_req = 0;
      end
      @(negedge clk_i);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    expected_map_t exp_item;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (pending_index.size() == 0) begin
          report_mismatch($sformatf("unexpected result index %0d", colour_index_o));
        end else begin
          exp_item = pending_index.pop_front();
          if (colour_index_o !== exp_item.index)
            report_mismatch($sformatf("pixel %04h: colour_index %0d, expected %0d",
                                      exp_item.pixel, colour_index_o, exp_item.index));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    mismatches     = 0;
    idle_cycles    = 0;
    hold_req       = 0;
    no_idle        = 1'b0;
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    action_i       = ACT_WRITE;
    entry_index_i  = '0;
    entry_colour_i = '0;
    pixel_i        = '0;
    for (int i = 0; i < N_SLOTS; i++) palette_copy[i] = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_palette_load();
    test_channel_extremes();
    test_lowest_index_ties();
    test_output_backpressure();
    test_random_stream(RANDOM_ITEMS);

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_index.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/npcm_pkg.sv
rtl/core/npcm_ram.sv
rtl/core/npcm_isqrt.sv
rtl/core/npcm_datapath.sv
rtl/core/npcm_ctrl.sv
rtl/core/nearest_palette_colour_mapper_core.sv
bench/tb.sv
